@@ sv/ccds_pkg.sv @@
// Shared types and constants for the cascaded counter divisor split unit.
package ccds_pkg;

    // Field widths.
    localparam int C_TOTAL_W = 32;
    localparam int C_CNT_W   = 16;
    localparam int C_DEN_W   = C_CNT_W + 1;
    localparam int C_STEP_W  = $clog2(C_TOTAL_W);

    // Default largest divisor a single counter can hold.
    localparam int C_COUNTER_MAX = 65535;

    // Request to the bit-serial divider.
    typedef struct packed {
        logic                 start;
        logic [C_TOTAL_W-1:0] dividend;
        logic [C_DEN_W-1:0]   divisor;
    } t_div_req;

    // Result of the bit-serial divider.
    typedef struct packed {
        logic                 done;
        logic [C_TOTAL_W-1:0] quotient;
        logic [C_DEN_W-1:0]   remainder;
    } t_div_res;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LO_GO,
        S_LO_WAIT,
        S_RANGE,
        S_TRY_GO,
        S_TRY_WAIT,
        S_DONE
    } t_state;

endpackage

@@ sv/ccds_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module ccds_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccds_pkg::t_div_req  i_req,
    output ccds_pkg::t_div_res  o_res
);

    logic                               r_busy;
    logic                               r_done;
    logic [ccds_pkg::C_STEP_W-1:0]      r_cnt;
    logic [ccds_pkg::C_DEN_W-1:0]       r_den;
    logic [ccds_pkg::C_DEN_W-1:0]       r_rem;
    logic [ccds_pkg::C_TOTAL_W-1:0]     r_quo;
    logic [ccds_pkg::C_DEN_W:0]         w_trial;
    logic                               w_ge;
    logic [ccds_pkg::C_DEN_W:0]         w_diff;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        w_trial = {r_rem, r_quo[ccds_pkg::C_TOTAL_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    // Control: busy flag, step count and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ccds_pkg::C_STEP_W'(ccds_pkg::C_TOTAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts into the dividend register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ccds_pkg::C_DEN_W-1:0] : w_trial[ccds_pkg::C_DEN_W-1:0];
            r_quo <= {r_quo[ccds_pkg::C_TOTAL_W-2:0], w_ge};
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

@@ sv/cascaded_counter_divisor_split_unit.sv @@
// Top level: splits a total divisor between two cascaded counters.
//
//  Channel | Valid    | Stall    | Payload
//  --------+----------+----------+---------------------------------------------------
//  input   | i_valid  | o_stall  | i_total_divisor
//  output  | o_valid  | i_stall  | o_wide_mode, o_first_divisor, o_second_divisor,
//          |          |          | o_out_of_range
//
//  A total below COUNTER_MAX goes straight to S_DONE, then to the output register.
//  Otherwise one division by COUNTER_MAX+1 finds the lowest useful factor, then
//  each trial factor costs one full pass of the bit-serial divider, which yields
//  one quotient bit per cycle.
//  Synchronous active-low reset clears the sequencer and the output valid.
//  A new request is taken while a finished result waits; a stalled output holds.
module cascaded_counter_divisor_split_unit #(
    parameter int COUNTER_MAX = ccds_pkg::C_COUNTER_MAX
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ccds_pkg::C_TOTAL_W-1:0]   i_total_divisor,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_wide_mode,
    output logic [ccds_pkg::C_CNT_W-1:0]     o_first_divisor,
    output logic [ccds_pkg::C_CNT_W-1:0]     o_second_divisor,
    output logic                             o_out_of_range
);

    localparam logic [ccds_pkg::C_TOTAL_W-1:0] LP_CMAX_T =
        ccds_pkg::C_TOTAL_W'(COUNTER_MAX);
    localparam logic [ccds_pkg::C_CNT_W-1:0]   LP_CMAX_C =
        ccds_pkg::C_CNT_W'(COUNTER_MAX);
    localparam logic [ccds_pkg::C_DEN_W-1:0]   LP_CMAX_DEN =
        ccds_pkg::C_DEN_W'(COUNTER_MAX + 1);

    ccds_pkg::t_state                  r_state, n_state;
    ccds_pkg::t_div_req                w_req;
    ccds_pkg::t_div_res                w_res;

    logic [ccds_pkg::C_TOTAL_W-1:0]    r_total;
    logic [ccds_pkg::C_TOTAL_W-1:0]    r_lo;
    logic [ccds_pkg::C_DEN_W-1:0]      r_f;
    logic [ccds_pkg::C_CNT_W-1:0]      r_limit;
    logic                              r_first_trial;
    logic [ccds_pkg::C_CNT_W-1:0]      r_q_lo;
    logic                              r_wide, r_oor;
    logic [ccds_pkg::C_CNT_W-1:0]      r_first, r_second;
    logic                              r_out_valid;
    logic                              r_out_wide, r_out_oor;
    logic [ccds_pkg::C_CNT_W-1:0]      r_out_first, r_out_second;

    logic                              w_accept;
    logic                              w_out_free;
    logic [ccds_pkg::C_TOTAL_W-1:0]    w_lo_raw;
    logic [ccds_pkg::C_CNT_W-1:0]      w_limit;
    logic                              w_exact;
    logic                              w_last;

    // Handshake terms.
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Lowest factor whose quotient fits, and the top of the search range.
    always_comb begin
        w_lo_raw = w_res.quotient + 1'b1;
        if ((r_total >> 1) > LP_CMAX_T) begin
            w_limit = LP_CMAX_C;
        end else begin
            w_limit = r_total[ccds_pkg::C_CNT_W:1];
        end
    end

    // Trial outcome.
    assign w_exact = (w_res.remainder == '0);
    assign w_last  = (r_f == {1'b0, r_limit});

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ccds_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_total_divisor < LP_CMAX_T) ? ccds_pkg::S_DONE
                                                            : ccds_pkg::S_LO_GO;
                end
            end
            ccds_pkg::S_LO_GO: n_state = ccds_pkg::S_LO_WAIT;
            ccds_pkg::S_LO_WAIT: begin
                if (w_res.done) begin
                    n_state = ccds_pkg::S_RANGE;
                end
            end
            ccds_pkg::S_RANGE: begin
                n_state = (r_lo > {16'd0, w_limit}) ? ccds_pkg::S_DONE
                                                    : ccds_pkg::S_TRY_GO;
            end
            ccds_pkg::S_TRY_GO: n_state = ccds_pkg::S_TRY_WAIT;
            ccds_pkg::S_TRY_WAIT: begin
                if (w_res.done) begin
                    n_state = (w_exact || w_last) ? ccds_pkg::S_DONE
                                                  : ccds_pkg::S_TRY_GO;
                end
            end
            ccds_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ccds_pkg::S_IDLE;
                end
            end
            default: n_state = ccds_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: input stall and the divider request.
    always_comb begin
        o_stall      = 1'b1;
        w_req.start  = 1'b0;
        w_req.dividend = r_total;
        w_req.divisor  = r_f;
        case (r_state)
            ccds_pkg::S_IDLE:  o_stall = 1'b0;
            ccds_pkg::S_LO_GO: begin
                w_req.start   = 1'b1;
                w_req.divisor = LP_CMAX_DEN;
            end
            ccds_pkg::S_TRY_GO: w_req.start = 1'b1;
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search datapath and the staged result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ccds_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_total  <= i_total_divisor;
                    r_wide   <= 1'b0;
                    r_oor    <= 1'b0;
                    r_first  <= i_total_divisor[ccds_pkg::C_CNT_W-1:0];
                    r_second <= '0;
                end
            end
            ccds_pkg::S_LO_WAIT: begin
                if (w_res.done) begin
                    r_lo <= (w_lo_raw < 32'd2) ? 32'd2 : w_lo_raw;
                end
            end
            ccds_pkg::S_RANGE: begin
                r_f           <= r_lo[ccds_pkg::C_DEN_W-1:0];
                r_limit       <= w_limit;
                r_first_trial <= 1'b1;
                // No factor in range: saturate.
                r_wide   <= 1'b1;
                r_oor    <= 1'b1;
                r_first  <= LP_CMAX_C;
                r_second <= LP_CMAX_C;
            end
            ccds_pkg::S_TRY_WAIT: begin
                if (w_res.done) begin
                    r_first_trial <= 1'b0;
                    if (r_first_trial) begin
                        r_q_lo <= w_res.quotient[ccds_pkg::C_CNT_W-1:0];
                    end
                    r_oor <= 1'b0;
                    if (w_exact) begin
                        r_first  <= r_f[ccds_pkg::C_CNT_W-1:0];
                        r_second <= w_res.quotient[ccds_pkg::C_CNT_W-1:0];
                    end else if (w_last) begin
                        // Fall back to the lowest factor with its truncated quotient.
                        r_first  <= r_lo[ccds_pkg::C_CNT_W-1:0];
                        r_second <= r_first_trial ?
                                    w_res.quotient[ccds_pkg::C_CNT_W-1:0] : r_q_lo;
                    end
                    r_f <= r_f + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ccds_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ccds_pkg::S_DONE && w_out_free) begin
            r_out_wide   <= r_wide;
            r_out_oor    <= r_oor;
            r_out_first  <= r_first;
            r_out_second <= r_second;
        end
    end

    ccds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    assign o_valid          = r_out_valid;
    assign o_wide_mode      = r_out_wide;
    assign o_out_of_range   = r_out_oor;
    assign o_first_divisor  = r_out_first;
    assign o_second_divisor = r_out_second;

endmodule

@@ sv/ccds_checker.sv @@
// Port-level assertions for the cascaded counter divisor split unit, with bind.
module ccds_checker #(
    parameter int COUNTER_MAX = ccds_pkg::C_COUNTER_MAX
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic [ccds_pkg::C_TOTAL_W-1:0]   i_total_divisor,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic                             o_wide_mode,
    input logic [ccds_pkg::C_CNT_W-1:0]     o_first_divisor,
    input logic [ccds_pkg::C_CNT_W-1:0]     o_second_divisor,
    input logic                             o_out_of_range
);

    localparam logic [ccds_pkg::C_CNT_W-1:0] LP_CMAX = ccds_pkg::C_CNT_W'(COUNTER_MAX);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_first_divisor)
                            && $stable(o_second_divisor) && $stable(o_wide_mode)
                            && $stable(o_out_of_range))
        else $error("stalled result changed");

    // The unit works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while busy");

    // Single mode never flags and leaves the second counter at zero.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_wide_mode |-> !o_out_of_range && o_second_divisor == '0)
        else $error("bad single-mode result");

    // Out of range saturates both counters in wide mode.
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_wide_mode && o_first_divisor == LP_CMAX
                                   && o_second_divisor == LP_CMAX)
        else $error("out of range without saturation");

    // A fitting wide pair has a first factor of at least two and a nonzero second.
    a_wide_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wide_mode && !o_out_of_range |->
            o_first_divisor >= 16'd2 && o_second_divisor != '0)
        else $error("bad wide-mode pair");

endmodule

bind cascaded_counter_divisor_split_unit ccds_checker #(
    .COUNTER_MAX(COUNTER_MAX)
) u_ccds_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_total_divisor  (i_total_divisor),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_wide_mode      (o_wide_mode),
    .o_first_divisor  (o_first_divisor),
    .o_second_divisor (o_second_divisor),
    .o_out_of_range   (o_out_of_range)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the cascaded counter divisor split unit.
`timescale 1ns / 1ps

module tb_top;

    localparam bit [31:0] CMAX          = ccds_pkg::C_COUNTER_MAX;
    localparam int        WATCHDOG_MAX  = 50000;
    localparam int        SETTLE_CYCLES = 40;

    // One divisor split as the block reports it.
    typedef struct packed {
        bit        wide;
        bit [15:0] first;
        bit [15:0] second;
        bit        saturated;
    } t_split;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [ccds_pkg::C_TOTAL_W-1:0] i_total_divisor = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic                           o_wide_mode;
    logic [ccds_pkg::C_CNT_W-1:0]   o_first_divisor;
    logic [ccds_pkg::C_CNT_W-1:0]   o_second_divisor;
    logic                           o_out_of_range;

    t_split      pending_splits[$];
    int unsigned idle_pct = 21;
    int unsigned mismatch_count = 0;
    int unsigned requests_sent = 0;
    int unsigned single_seen = 0;
    int unsigned cascaded_seen = 0;
    int unsigned saturated_seen = 0;
    int unsigned quiet_cycles = 0;

    cascaded_counter_divisor_split_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_total_divisor  (i_total_divisor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_wide_mode      (o_wide_mode),
        .o_first_divisor  (o_first_divisor),
        .o_second_divisor (o_second_divisor),
        .o_out_of_range   (o_out_of_range)
    );

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // Computes the split the block should report for one total.
    function automatic t_split predict_split(input bit [31:0] total);
        bit [31:0] upper;
        bit [31:0] lo;
        bit [31:0] f;
        bit [31:0] fst;
        bit [31:0] sec;
        bit        hit;
        t_split    r;
        r   = '0;
        hit = 1'b0;
        fst = '0;
        sec = '0;
        if (total < CMAX) begin
            r.first = total[15:0];
            return r;
        end
        upper = total / 2;
        if (upper > CMAX) begin
            upper = CMAX;
        end
        // No factor below this one can leave a quotient that fits.
        lo = total / (CMAX + 1) + 1;
        if (lo < 2) begin
            lo = 2;
        end
        // Smallest exact factor first.
        for (f = lo; f <= upper && !hit; f++) begin
            if (total % f == 0) begin
                fst = f;
                sec = total / f;
                hit = 1'b1;
            end
        end
        // Otherwise the smallest factor whose truncated quotient fits.
        if (!hit && lo <= upper) begin
            fst = lo;
            sec = total / lo;
            hit = 1'b1;
        end
        r.wide = 1'b1;
        if (!hit || sec > CMAX || fst > CMAX) begin
            r.first     = CMAX[15:0];
            r.second    = CMAX[15:0];
            r.saturated = 1'b1;
        end else begin
            r.first  = fst[15:0];
            r.second = sec[15:0];
        end
        return r;
    endfunction

    // Draws a total whose factor search stays short.
    function automatic bit [31:0] random_total();
        int unsigned pick;
        bit [31:0]   a;
        bit [31:0]   d;
        bit [31:0]   dmax;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            return $urandom_range(0, CMAX - 1);
        end
        if (pick < 70) begin
            // A product a * b with b close enough to the top that the
            // search from the lowest useful factor up to a is short.
            a    = $urandom_range(2, 65535);
            dmax = 6553600 / a;
            if (dmax > 65534) begin
                dmax = 65534;
            end
            d = $urandom_range(1, dmax);
            return a * (32'd65536 - d);
        end
        if (pick < 88) begin
            // The top band: few trials, then truncated, exact or saturated.
            return $urandom_range(32'hFFFA_0000, 32'hFFFF_FFFF);
        end
        // Even totals around the single counter limit.
        a = $urandom_range(32760, 32800);
        return a << 1;
    endfunction

    // Sends one request; starts and ends at a falling edge.
    task automatic send_total(input bit [31:0] total);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_total_divisor <= total;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        pending_splits.push_back(predict_split(total));
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected split has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending_splits.size() != 0);
    endtask

    task automatic test_single_mode();
        send_total(32'd0);
        send_total(32'd1);
        send_total(32'd2);
        send_total(32'h0000_5555);
        send_total(32'h0000_AAAA);
        send_total(CMAX - 1);
        drain_results();
    endtask

    task automatic test_counter_boundary();
        send_total(CMAX);
        send_total(CMAX + 1);
        send_total(32'd131070);
        send_total(32'd131072);
        drain_results();
    endtask

    task automatic test_exact_split();
        send_total(32'd196605);
        send_total(32'd458647);
        send_total(32'd65000000);
        send_total(32'd3932100000);
        send_total(32'hFFFE_0001);
        drain_results();
    endtask

    task automatic test_truncated_split();
        send_total(32'hFFFE_FFFF);
        send_total(32'hFFFE_FFFE);
        send_total(32'd4294574081);
        drain_results();
    endtask

    task automatic test_out_of_range();
        send_total(32'hFFFF_0000);
        send_total(32'hFFFF_8000);
        send_total(32'hFFFF_FFFF);
        drain_results();
    endtask

    // A long stretch where neither side idles.
    task automatic test_back_to_back();
        idle_pct = 0;
        repeat (25) send_total(random_total());
        drain_results();
        idle_pct = 21;
    endtask

    task automatic test_random_mix();
        repeat (54) send_total(random_total());
        drain_results();
    endtask

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // Compares each accepted split with the oldest expectation.
    always @(posedge i_clk) begin
        t_split want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_splits.size() == 0) begin
                $error("split result with no request waiting");
                mismatch_count++;
            end else begin
                want = pending_splits.pop_front();
                if (o_wide_mode !== want.wide) begin
                    $error("wide_mode: expected %0d, got %0d", want.wide, o_wide_mode);
                    mismatch_count++;
                end
                if (o_first_divisor !== want.first) begin
                    $error("first_divisor: expected %0d, got %0d",
                           want.first, o_first_divisor);
                    mismatch_count++;
                end
                if (o_second_divisor !== want.second) begin
                    $error("second_divisor: expected %0d, got %0d",
                           want.second, o_second_divisor);
                    mismatch_count++;
                end
                if (o_out_of_range !== want.saturated) begin
                    $error("out_of_range: expected %0d, got %0d",
                           want.saturated, o_out_of_range);
                    mismatch_count++;
                end
            end
            if (o_out_of_range === 1'b1) begin
                saturated_seen++;
            end else if (o_wide_mode === 1'b1) begin
                cascaded_seen++;
            end else begin
                single_seen++;
            end
        end
    end

    // Ends a run in which nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_single_mode();
        test_counter_boundary();
        test_exact_split();
        test_truncated_split();
        test_out_of_range();
        test_back_to_back();
        test_random_mix();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d totals with random gaps, stalls and a burst without either.",
                 requests_sent);
        $display("Results: %0d single counter, %0d cascaded, %0d saturated.",
                 single_seen, cascaded_seen, saturated_seen);
        if (mismatch_count == 0 && pending_splits.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
